// ----- hw/rtl/lrz_pkg.sv -----
// lrz_pkg: shared constants, config types and saturating fixed-point helpers
// for the lorenz63 rk4 integrator; no dependencies
package lrz_pkg;

    localparam int LRZ_MAX_ROWS  = 64;
    localparam int LRZ_ROW_W     = $clog2(LRZ_MAX_ROWS);
    localparam int LRZ_CNT_W     = LRZ_ROW_W + 1;
    localparam int LRZ_CFG_IDX_W = 3;

    // register indexes of the config port
    localparam logic [LRZ_CFG_IDX_W-1:0] CFG_SIGMA   = 3'd0;
    localparam logic [LRZ_CFG_IDX_W-1:0] CFG_RHO     = 3'd1;
    localparam logic [LRZ_CFG_IDX_W-1:0] CFG_BETA    = 3'd2;
    localparam logic [LRZ_CFG_IDX_W-1:0] CFG_DT      = 3'd3;
    localparam logic [LRZ_CFG_IDX_W-1:0] CFG_STEPS   = 3'd4;
    localparam logic [LRZ_CFG_IDX_W-1:0] CFG_SAMPLES = 3'd5;

    // floor(2^34 / 6) + 1, exact quotient by 6 for 32-bit dividends
    localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;

    typedef struct packed {
        logic signed [31:0] sigma;
        logic signed [31:0] rho;
        logic signed [31:0] beta;
        logic [15:0]        time_step;
        logic [15:0]        steps;
        logic [6:0]         samples;
    } t_cfg;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] f_sat(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] f_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] res;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            res = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] f_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] res;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) begin
            res = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

    // shift right by 16 (full) or 17, round half away from zero, saturate
    function automatic logic signed [31:0] f_rnd(input logic signed [65:0] p,
                                                 input logic full);
        logic signed [65:0] r;
        logic signed [31:0] res;
        r = p + (full ? 66'sd32768 : 66'sd65536) - $signed({65'b0, p[65]});
        if (full) begin
            res = f_sat(r >>> 16);
        end else begin
            res = f_sat(r >>> 17);
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/lrz_in_if.sv -----
// lrz_in_if: start point channel, valid/ready with the initial coordinates
// depends on nothing
interface lrz_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;

    modport source (output valid, start_x, start_y, start_z, input ready);
    modport sink   (input valid, start_x, start_y, start_z, output ready);
endinterface

// ----- hw/rtl/lrz_out_if.sv -----
// lrz_out_if: trajectory row channel, valid/ready with one row per transaction
// depends on nothing
interface lrz_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [5:0]         row_index;
    logic               last_row;

    modport source (output valid, pos_x, pos_y, pos_z, row_index, last_row,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, row_index, last_row,
                    output ready);
endinterface

// ----- hw/rtl/lrz_cfg.sv -----
// lrz_cfg: configuration register file with reset defaults
// depends on lrz_pkg
module lrz_cfg import lrz_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [LRZ_CFG_IDX_W-1:0] i_idx,
    input  logic [31:0]              i_data,
    output t_cfg                     o_cfg
);
    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sigma     <= 32'sd655360;
            r_cfg.rho       <= 32'sd1835008;
            r_cfg.beta      <= 32'sd174763;
            r_cfg.time_step <= 16'd655;
            r_cfg.steps     <= 16'd1;
            r_cfg.samples   <= 7'd64;
        end else if (i_we) begin
            case (i_idx)
                CFG_SIGMA:   r_cfg.sigma     <= i_data;
                CFG_RHO:     r_cfg.rho       <= i_data;
                CFG_BETA:    r_cfg.beta      <= i_data;
                CFG_DT:      r_cfg.time_step <= i_data[15:0];
                CFG_STEPS:   r_cfg.steps     <= i_data[15:0];
                CFG_SAMPLES: r_cfg.samples   <= i_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ----- hw/rtl/lrz_mul.sv -----
// lrz_mul: shared 33x33 signed multiplier with registered product
// depends on nothing
module lrz_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_prod
);
    logic signed [65:0] r_prod;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

// ----- hw/rtl/lorenz63_rk4_integrator.sv -----
// lorenz63_rk4_integrator: lorenz-63 rk4 trajectory generator, top level
// depends on lrz_pkg, lrz_in_if, lrz_out_if, lrz_cfg, lrz_mul
//
//  channel   dir  transaction
//  i_start   in   initial point start_x/y/z, opens a trajectory
//  o_traj    out  one row: pos_x/y/z, row_index, last_row
//  i_cfg_*   in   register write, index and data, no handshake
//
// one rk4 step is 31 passes through the shared multiplier, each a multiply
// state and a write-back state, plus one slope-sum state per rk4 stage;
// each row after the first is shown after steps_per_sample rk4 steps.
// i_start is ready only while idle; a stalled o_traj holds the sequencer.
// reset is synchronous and returns the block to idle.
module lorenz63_rk4_integrator import lrz_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lrz_in_if.sink                   i_start,
    lrz_out_if.source                o_traj,
    input  logic                     i_cfg_we,
    input  logic [LRZ_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]              i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EMIT = 5'b00010,
        S_MUL  = 5'b00100,
        S_WB   = 5'b01000,
        S_ACC  = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        U_D0, U_D1, U_D2A, U_D2B, U_OFF, U_FIN, U_DIV
    } t_uop;

    t_cfg cfg;

    t_state r_state, n_state;
    t_uop   r_uop, n_uop;
    logic [1:0]  r_lane, n_lane;
    logic [1:0]  r_stage, n_stage;
    logic [15:0] r_step, n_step;
    logic [LRZ_ROW_W-1:0] r_row, n_row;
    logic [LRZ_CNT_W-1:0] r_rows, n_rows;
    logic signed [31:0] r_cur [0:2], n_cur [0:2];
    logic signed [31:0] r_pt  [0:2], n_pt  [0:2];
    logic signed [31:0] r_ks  [0:2], n_ks  [0:2];
    logic signed [31:0] r_sum [0:2], n_sum [0:2];
    logic signed [31:0] r_t, n_t;
    logic        r_neg, n_neg;
    logic [32:0] r_u, n_u;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [31:0] q16, opnd, quot_s;
    logic signed [65:0] prod_abs;
    logic [48:0]        biased;
    logic [30:0]        quot;
    logic               last;
    logic [LRZ_CNT_W-1:0] rows_clamp;

    lrz_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    lrz_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_prod(prod)
    );

    // multiplier operand select per micro-op
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        opnd  = '0;
        case (r_uop)
            U_D0: begin
                opnd  = f_sub(r_pt[1], r_pt[0]);
                mul_a = {cfg.sigma[31], cfg.sigma};
                mul_b = {opnd[31], opnd};
            end
            U_D1: begin
                opnd  = f_sub(cfg.rho, r_pt[2]);
                mul_a = {r_pt[0][31], r_pt[0]};
                mul_b = {opnd[31], opnd};
            end
            U_D2A: begin
                mul_a = {r_pt[0][31], r_pt[0]};
                mul_b = {r_pt[1][31], r_pt[1]};
            end
            U_D2B: begin
                mul_a = {cfg.beta[31], cfg.beta};
                mul_b = {r_pt[2][31], r_pt[2]};
            end
            U_OFF: begin
                mul_a = $signed({17'b0, cfg.time_step});
                mul_b = {r_ks[r_lane][31], r_ks[r_lane]};
            end
            U_FIN: begin
                mul_a = $signed({17'b0, cfg.time_step});
                mul_b = {r_sum[r_lane][31], r_sum[r_lane]};
            end
            U_DIV: begin
                mul_a = $signed(r_u);
                mul_b = $signed({1'b0, RECIP6});
            end
            default: ;
        endcase
    end

    // product post-processing
    assign q16      = f_rnd(prod, 1'b1);
    assign prod_abs = prod[65] ? -prod : prod;
    assign biased   = {1'b0, prod_abs[47:0]} + 49'd196608;
    assign quot     = prod[64:34];
    assign quot_s   = r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    assign last = ({1'b0, r_row} + 1'b1) == r_rows;
    assign rows_clamp = (cfg.samples == 7'd0) ? LRZ_CNT_W'(1) :
                        (cfg.samples > 7'(LRZ_MAX_ROWS)) ? LRZ_CNT_W'(LRZ_MAX_ROWS) :
                        LRZ_CNT_W'(cfg.samples);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_uop   = r_uop;
        n_lane  = r_lane;
        n_stage = r_stage;
        n_step  = r_step;
        n_row   = r_row;
        n_rows  = r_rows;
        n_cur   = r_cur;
        n_pt    = r_pt;
        n_ks    = r_ks;
        n_sum   = r_sum;
        n_t     = r_t;
        n_neg   = r_neg;
        n_u     = r_u;
        case (r_state)
            S_IDLE: begin
                if (i_start.valid) begin
                    n_cur[0] = i_start.start_x;
                    n_cur[1] = i_start.start_y;
                    n_cur[2] = i_start.start_z;
                    n_row    = '0;
                    n_rows   = rows_clamp;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                if (o_traj.ready) begin
                    if (last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                        if (cfg.steps != 16'd0) begin
                            n_step  = '0;
                            n_pt    = r_cur;
                            n_stage = '0;
                            n_lane  = '0;
                            n_uop   = U_D0;
                            n_state = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                n_state = S_WB;
            end
            S_WB: begin
                n_state = S_MUL;
                case (r_uop)
                    U_D0: begin
                        n_ks[0] = q16;
                        n_uop   = U_D1;
                    end
                    U_D1: begin
                        n_ks[1] = f_sub(q16, r_pt[1]);
                        n_uop   = U_D2A;
                    end
                    U_D2A: begin
                        n_t   = q16;
                        n_uop = U_D2B;
                    end
                    U_D2B: begin
                        n_ks[2] = f_sub(r_t, q16);
                        n_state = S_ACC;
                    end
                    U_OFF: begin
                        n_pt[r_lane] = f_add(r_cur[r_lane],
                                             f_rnd(prod, r_stage == 2'd2));
                        if (r_lane == 2'd2) begin
                            n_lane  = '0;
                            n_stage = r_stage + 1'b1;
                            n_uop   = U_D0;
                        end else begin
                            n_lane = r_lane + 1'b1;
                        end
                    end
                    U_FIN: begin
                        n_neg = prod[65];
                        n_u   = biased[48:16];
                        n_uop = U_DIV;
                    end
                    U_DIV: begin
                        n_cur[r_lane] = f_add(r_cur[r_lane], quot_s);
                        if (r_lane == 2'd2) begin
                            // step finished
                            if ({1'b0, r_step} + 17'd1 == {1'b0, cfg.steps}) begin
                                n_state = S_EMIT;
                            end else begin
                                n_step  = r_step + 1'b1;
                                n_pt    = n_cur;
                                n_stage = '0;
                                n_lane  = '0;
                                n_uop   = U_D0;
                            end
                        end else begin
                            n_lane = r_lane + 1'b1;
                            n_uop  = U_FIN;
                        end
                    end
                    default: ;
                endcase
            end
            S_ACC: begin
                // weighted slope sum, weights 1 2 2 1
                for (int i = 0; i < 3; i++) begin
                    case (r_stage)
                        2'd0:    n_sum[i] = r_ks[i];
                        2'd3:    n_sum[i] = f_add(r_sum[i], r_ks[i]);
                        default: n_sum[i] = f_add(r_sum[i], f_add(r_ks[i], r_ks[i]));
                    endcase
                end
                n_lane  = '0;
                n_uop   = (r_stage == 2'd3) ? U_FIN : U_OFF;
                n_state = S_MUL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_uop   <= U_D0;
            r_lane  <= '0;
            r_stage <= '0;
            r_step  <= '0;
            r_row   <= '0;
            r_rows  <= LRZ_CNT_W'(1);
        end else begin
            r_state <= n_state;
            r_uop   <= n_uop;
            r_lane  <= n_lane;
            r_stage <= n_stage;
            r_step  <= n_step;
            r_row   <= n_row;
            r_rows  <= n_rows;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_pt  <= n_pt;
        r_ks  <= n_ks;
        r_sum <= n_sum;
        r_t   <= n_t;
        r_neg <= n_neg;
        r_u   <= n_u;
    end

    // ports
    assign i_start.ready    = (r_state == S_IDLE);
    assign o_traj.valid     = (r_state == S_EMIT);
    assign o_traj.pos_x     = r_cur[0];
    assign o_traj.pos_y     = r_cur[1];
    assign o_traj.pos_z     = r_cur[2];
    assign o_traj.row_index = r_row;
    assign o_traj.last_row  = last;

    // checks
    a_first_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start.valid && i_start.ready) |=> (o_traj.valid && r_row == '0))
        else $error("trajectory did not open with row 0");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_traj.valid && o_traj.ready && o_traj.last_row) |=> i_start.ready)
        else $error("not idle after last row");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_traj.valid && o_traj.ready && !o_traj.last_row) |=> !i_start.ready)
        else $error("accepting a start mid trajectory");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_traj.valid |-> ({1'b0, r_row} < r_rows))
        else $error("row index beyond row count");

endmodule

// ----- tb/lrz_traj_checker.sv -----
// lrz_traj_checker: watches the start, trajectory and config ports, predicts
// every trajectory row in Q16.16 and compares; depends on lrz_pkg, lrz_in_if, lrz_out_if
module lrz_traj_checker import lrz_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lrz_in_if                        start_ch,
    lrz_out_if                       traj_ch,
    input  logic                     i_cfg_we,
    input  logic [LRZ_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]              i_cfg_data,
    output int                       o_fail_cnt,
    output int                       o_rows_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint t_trip [3];

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [5:0]         row;
        logic               last;
    } t_row;

    t_row   rows_q[$];
    t_cfg   cfg;
    int     fails;
    int     pending;

    assign o_fail_cnt     = fails;
    assign o_rows_pending = pending;

    // saturating q16.16 arithmetic
    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // divide rounding half away from zero
    function automatic longint round_div(longint p, longint d);
        longint m;
        longint q;
        m = (p < 0) ? -p : p;
        q = (m + d / 2) / d;
        return (p < 0) ? -q : q;
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clip32(a + b);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return clip32(a - b);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clip32(round_div(a * b, 65536));
    endfunction

    // lorenz-63 vector field
    function automatic t_trip lorenz_slope(t_trip p);
        t_trip d;
        longint sg;
        longint rh;
        longint bt;
        sg = longint'(cfg.sigma);
        rh = longint'(cfg.rho);
        bt = longint'(cfg.beta);
        d[0] = qmul(sg, qsub(p[1], p[0]));
        d[1] = qsub(qmul(p[0], qsub(rh, p[2])), p[1]);
        d[2] = qsub(qmul(p[0], p[1]), qmul(bt, p[2]));
        return d;
    endfunction

    // base + dt*k/divisor per axis
    function automatic t_trip advance(t_trip base, t_trip k, longint divisor);
        t_trip r;
        for (int i = 0; i < 3; i++) begin
            r[i] = qadd(base[i], clip32(round_div(longint'(cfg.time_step) * k[i], divisor)));
        end
        return r;
    endfunction

    function automatic t_trip rk4_advance(t_trip cur);
        t_trip k;
        t_trip s;
        t_trip p;
        k = lorenz_slope(cur);
        s = k;
        p = advance(cur, k, 131072);
        k = lorenz_slope(p);
        for (int i = 0; i < 3; i++) s[i] = qadd(s[i], qadd(k[i], k[i]));
        p = advance(cur, k, 131072);
        k = lorenz_slope(p);
        for (int i = 0; i < 3; i++) s[i] = qadd(s[i], qadd(k[i], k[i]));
        p = advance(cur, k, 65536);
        k = lorenz_slope(p);
        for (int i = 0; i < 3; i++) s[i] = qadd(s[i], k[i]);
        return advance(cur, s, 393216);
    endfunction

    // queue every row of one trajectory
    task automatic predict_trajectory(logic signed [31:0] sx, logic signed [31:0] sy,
                                      logic signed [31:0] sz);
        t_trip cur;
        int    n_rows;
        t_row  r;
        cur[0] = longint'(sx);
        cur[1] = longint'(sy);
        cur[2] = longint'(sz);
        n_rows = int'(cfg.samples);
        if (n_rows < 1) n_rows = 1;
        if (n_rows > LRZ_MAX_ROWS) n_rows = LRZ_MAX_ROWS;
        for (int ri = 0; ri < n_rows; ri++) begin
            if (ri > 0) begin
                for (int st = 0; st < int'(cfg.steps); st++) cur = rk4_advance(cur);
            end
            r.x    = cur[0][31:0];
            r.y    = cur[1][31:0];
            r.z    = cur[2][31:0];
            r.row  = ri[5:0];
            r.last = (ri + 1 == n_rows);
            rows_q.push_back(r);
        end
    endtask

    // config shadow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.sigma     <= 32'sd655360;
            cfg.rho       <= 32'sd1835008;
            cfg.beta      <= 32'sd174763;
            cfg.time_step <= 16'd655;
            cfg.steps     <= 16'd1;
            cfg.samples   <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIGMA:   cfg.sigma     <= i_cfg_data;
                CFG_RHO:     cfg.rho       <= i_cfg_data;
                CFG_BETA:    cfg.beta      <= i_cfg_data;
                CFG_DT:      cfg.time_step <= i_cfg_data[15:0];
                CFG_STEPS:   cfg.steps     <= i_cfg_data[15:0];
                CFG_SAMPLES: cfg.samples   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // start transaction: predict; row transaction: compare
    initial begin
        fails   = 0;
        pending = 0;
    end
    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && start_ch.valid && start_ch.ready) begin
            predict_trajectory(start_ch.start_x, start_ch.start_y, start_ch.start_z);
        end
        if (i_rst_n && traj_ch.valid && traj_ch.ready) begin
            if (rows_q.size() == 0) begin
                $display("%0t: unexpected row x=%h y=%h z=%h row=%0d", $time,
                         traj_ch.pos_x, traj_ch.pos_y, traj_ch.pos_z, traj_ch.row_index);
                fails++;
            end else begin
                e = rows_q.pop_front();
                if (traj_ch.pos_x !== e.x || traj_ch.pos_y !== e.y || traj_ch.pos_z !== e.z
                    || traj_ch.row_index !== e.row || traj_ch.last_row !== e.last) begin
                    $display("%0t: row mismatch exp x=%h y=%h z=%h row=%0d last=%b", $time,
                             e.x, e.y, e.z, e.row, e.last);
                    $display("%0t:              got x=%h y=%h z=%h row=%0d last=%b", $time,
                             traj_ch.pos_x, traj_ch.pos_y, traj_ch.pos_z,
                             traj_ch.row_index, traj_ch.last_row);
                    fails++;
                end
            end
        end
        pending = rows_q.size();
    end

endmodule

// ----- tb/tb_lorenz63_rk4_integrator.sv -----
// tb_lorenz63_rk4_integrator: stimulus and verdict for the lorenz63 rk4 integrator
// depends on lrz_pkg, lrz_in_if, lrz_out_if, lrz_traj_checker and the block itself
module tb_lorenz63_rk4_integrator;
    import lrz_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [LRZ_CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
    localparam int  CYCLE_LIMIT = 20000000;
    localparam int  ONE         = 65536;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [LRZ_CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]              cfg_data;
    int                       fail_cnt;
    int                       rows_pending;
    int                       cycles;
    bit                       quiet;
    bit                       hold_req;

    lrz_in_if  start_ch ();
    lrz_out_if traj_ch ();

    lorenz63_rk4_integrator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_ch),
        .o_traj     (traj_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lrz_traj_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start_ch       (start_ch),
        .traj_ch        (traj_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_cnt     (fail_cnt),
        .o_rows_pending (rows_pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL lorenz63_rk4_integrator");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        traj_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                traj_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                traj_ch.ready <= 1'b1;
                n = quiet ? 0 : $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
            end else begin
                traj_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(posedge i_clk);
            end
        end
    end

    // one start transaction, with an optional idle burst ahead of it
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            start_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start_ch.valid   <= 1'b1;
        start_ch.start_x <= x;
        start_ch.start_y <= y;
        start_ch.start_z <= z;
        @(posedge i_clk);
        while (!start_ch.ready) @(posedge i_clk);
    endtask

    // wait for the trajectory to drain, then let the block settle
    task automatic drain();
        start_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (rows_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // write every register, plus the unused index, back to back
    task automatic apply_cfg(logic [31:0] sg, logic [31:0] rh, logic [31:0] bt,
                             logic [15:0] dt, logic [15:0] steps, logic [6:0] samples);
        logic [31:0] vals [7];
        logic [LRZ_CFG_IDX_W-1:0] idxs [7];
        vals = '{sg, rh, bt, {16'h0, dt}, {16'h0, steps}, {25'h0, samples}, $urandom()};
        idxs = '{CFG_SIGMA, CFG_RHO, CFG_BETA, CFG_DT, CFG_STEPS, CFG_SAMPLES, CFG_SPARE};
        for (int i = 0; i < 7; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[i];
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $urandom_range(0, 60 * ONE) - 30 * ONE;
    endfunction

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 4) == 0) return $urandom();
        return $urandom_range(0, 40 * ONE) - 5 * ONE;
    endfunction

    initial begin
        logic [6:0] samp;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_SIGMA;
        cfg_data         <= '0;
        start_ch.valid   <= 1'b0;
        start_ch.start_x <= '0;
        start_ch.start_y <= '0;
        start_ch.start_z <= '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, full 64-row trajectories
        send_point(ONE, ONE, ONE);
        send_point(32'h0, 32'h0, 32'h0);
        drain();

        // extreme coefficients and points, saturation everywhere
        apply_cfg(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'd2, 7'd4);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
        drain();
        apply_cfg(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'd1, 7'd3);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(5 * ONE, -7 * ONE, 20 * ONE);
        drain();

        // row count below and above range, zero steps
        apply_cfg(10 * ONE, 28 * ONE, 174763, 16'd655, 16'd0, 7'd0);
        send_point(ONE, 2 * ONE, 3 * ONE);
        drain();
        apply_cfg(10 * ONE, 28 * ONE, 174763, 16'd655, 16'd1, 7'd127);
        send_point(ONE, ONE, ONE);
        drain();
        apply_cfg(10 * ONE, 28 * ONE, 174763, 16'hFFFF, 16'd0, 7'd5);
        send_point(-3 * ONE, 4 * ONE, 9 * ONE);
        drain();
        // largest step count, single row only
        apply_cfg(10 * ONE, 28 * ONE, 174763, 16'd655, 16'hFFFF, 7'd1);
        send_point(ONE, ONE, ONE);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();
        apply_cfg(10 * ONE, 28 * ONE, 174763, 16'd1000, 16'd1, 7'd2);
        send_point(ONE, 0, 0);
        drain();

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            samp = ($urandom_range(0, 9) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 8));
            apply_cfg(rand_coef(), rand_coef(), rand_coef(), 16'($urandom()),
                      16'($urandom_range(0, 3)), samp);
            quiet = (ph == 9);
            for (int it = 0; it < 20; it++) begin
                if (ph == 4 && it == 3) hold_req = 1'b1;
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        if (fail_cnt == 0) begin
            $display("PASS lorenz63_rk4_integrator");
        end else begin
            $display("FAIL lorenz63_rk4_integrator");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lrz_pkg.sv
hw/rtl/lrz_in_if.sv
hw/rtl/lrz_out_if.sv
hw/rtl/lrz_cfg.sv
hw/rtl/lrz_mul.sv
hw/rtl/lorenz63_rk4_integrator.sv
tb/lrz_traj_checker.sv
tb/tb_lorenz63_rk4_integrator.sv
